// ===== hw/rtl/ptr_pkg.sv =====
`default_nettype none

package ptr_pkg;

	localparam int DATA_WIDTH  = 16;
	localparam int ANGLE_WIDTH = 16;
	localparam int FRAC        = DATA_WIDTH - 1;
	localparam int RES_WIDTH   = DATA_WIDTH + 1;
	localparam int OFF_WIDTH   = ANGLE_WIDTH - 2;
	localparam int ROM_DEPTH   = 2 ** OFF_WIDTH;
	localparam int ACC_WIDTH   = 2 * DATA_WIDTH + 1;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic REG_DIRECTION = 1'b0;

	localparam logic DIR_FORWARD = 1'b0;
	localparam logic DIR_INVERSE = 1'b1;

	localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

	typedef logic signed [DATA_WIDTH-1:0]  data_t;
	typedef logic        [ANGLE_WIDTH-1:0] angle_t;
	typedef logic        [OFF_WIDTH-1:0]   offset_t;
	typedef logic signed [RES_WIDTH-1:0]   res_t;
	typedef logic        [FRAC-1:0]        mag_t;
	typedef logic signed [2*DATA_WIDTH-1:0] prod_t;
	typedef logic signed [ACC_WIDTH-1:0]   acc_t;

	localparam acc_t ROUND_HALF = acc_t'(2 ** (FRAC - 1));

	typedef struct packed {
		mag_t sin_v;
		mag_t cos_v;
	} trig_t;

	typedef struct packed {
		logic en_a;
		logic en_b;
		logic sub;
	} cell_ctl_t;

	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// Divides a series term by (m+1)(m+2), where m is the exponent of the previous term.
	function automatic logic [63:0] div_step(input logic [63:0] p, input int m);
		logic [63:0] q;
		case (m)
			0:  q = p / 2;
			1:  q = p / 6;
			2:  q = p / 12;
			3:  q = p / 20;
			4:  q = p / 30;
			5:  q = p / 42;
			6:  q = p / 56;
			7:  q = p / 72;
			8:  q = p / 90;
			9:  q = p / 110;
			10: q = p / 132;
			11: q = p / 156;
			12: q = p / 182;
			13: q = p / 210;
			14: q = p / 240;
			15: q = p / 272;
			16: q = p / 306;
			17: q = p / 342;
			18: q = p / 380;
			19: q = p / 420;
			20: q = p / 462;
			21: q = p / 506;
			22: q = p / 552;
			23: q = p / 600;
			24: q = p / 650;
			25: q = p / 702;
			26: q = p / 756;
			27: q = p / 812;
			default: q = p;
		endcase
		return q;
	endfunction

	function automatic logic [63:0] series(input logic [63:0] th2, input logic [63:0] start,
			input int first);
		logic [63:0] term;
		logic [63:0] sum;
		int n;
		term = start;
		sum  = start;
		n    = first;
		for (int k = 0; k < 14; k++) begin
			term = div_step(mul_q62(term, th2), n);
			n = n + 2;
			if (k[0]) begin
				sum = sum + term;
			end else begin
				sum = sum - term;
			end
		end
		return sum;
	endfunction

	function automatic mag_t to_frac(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] top;
		r   = (v + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
		top = (64'd1 << FRAC) - 64'd1;
		if (r > top) begin
			r = top;
		end
		return r[FRAC-1:0];
	endfunction

	function automatic trig_t trig_entry(input offset_t x);
		logic [63:0] xv;
		logic [63:0] th;
		logic [63:0] th2;
		trig_t t;
		xv = 64'(x) << (64 - ANGLE_WIDTH);
		th  = mul_q62(xv, HALF_PI_Q62);
		th2 = mul_q62(th, th);
		t.sin_v = to_frac(series(th2, th, 1));
		t.cos_v = to_frac(series(th2, ONE_Q62, 0));
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ptr_vec_if.sv =====
`default_nettype none

interface ptr_vec_if;
	import ptr_pkg::*;

	logic   valid;
	logic   ready;
	data_t  first_component;
	data_t  second_component;
	angle_t rotor_angle;

	modport source (output valid, output first_component, output second_component,
		output rotor_angle, input ready);
	modport sink (input valid, input first_component, input second_component,
		input rotor_angle, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ptr_res_if.sv =====
`default_nettype none

interface ptr_res_if;
	import ptr_pkg::*;

	logic valid;
	logic ready;
	res_t first_result;
	res_t second_result;

	modport source (output valid, output first_result, output second_result, input ready);
	modport sink (input valid, input first_result, input second_result, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ptr_rom.sv =====
`default_nettype none

module ptr_rom (
	input  wire               clk,
	input  wire               rd_en,
	input  ptr_pkg::offset_t  addr,
	output ptr_pkg::trig_t    rd_data
);
	import ptr_pkg::*;

	// Sine and cosine of the offset within the first quadrant.
	trig_t rom_mem [ROM_DEPTH];
	trig_t rd_q;

	initial begin
		for (int i = 0; i < ROM_DEPTH; i++) begin
			rom_mem[i] = trig_entry(OFF_WIDTH'(i));
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= rom_mem[addr];
		end
	end

	assign rd_data = rd_q;
endmodule

`default_nettype wire

// ===== hw/rtl/ptr_cell.sv =====
`default_nettype none

module ptr_cell (
	input  wire                 clk,
	input  ptr_pkg::cell_ctl_t  ctl,
	input  ptr_pkg::data_t      a,
	input  ptr_pkg::data_t      b,
	input  ptr_pkg::data_t      sin_v,
	input  ptr_pkg::data_t      cos_v,
	output ptr_pkg::res_t       res
);
	import ptr_pkg::*;

	prod_t p_cos_s2;
	prod_t p_sin_s2;
	logic  sub_s2;
	acc_t  sum;
	acc_t  rnd;
	acc_t  shifted;
	res_t  res_q;

	always_ff @(posedge clk) begin
		if (ctl.en_a) begin
			p_cos_s2 <= a * cos_v;
			p_sin_s2 <= b * sin_v;
			sub_s2   <= ctl.sub;
		end
	end

	always_comb begin
		if (sub_s2) begin
			sum = acc_t'(p_cos_s2) - acc_t'(p_sin_s2);
		end else begin
			sum = acc_t'(p_cos_s2) + acc_t'(p_sin_s2);
		end
		rnd     = sum + ROUND_HALF;
		shifted = rnd >>> FRAC;
	end

	always_ff @(posedge clk) begin
		if (ctl.en_b) begin
			res_q <= shifted[RES_WIDTH-1:0];
		end
	end

	assign res = res_q;
endmodule

`default_nettype wire

// ===== hw/rtl/park_transform_core.sv =====
`default_nettype none

// Channel  Role    Payload
// vec      sink    first_component, second_component, rotor_angle
// res      source  first_result, second_result
// apb      slave   direction register at byte address 0
//
// Each request passes the registered table read, the registered products in each
// cell and the output register before its result is valid. One request can enter
// every cycle unless every stage is full behind a stalled result.
// Reset clears the pipeline valid bits and the direction register.
// A stalled result holds the output; earlier stages keep filling until full.

module park_transform_core (
	input  wire                     clk,
	input  wire                     arst_n,
	ptr_vec_if.sink                 vec,
	ptr_res_if.source               res,
	input  wire                     psel,
	input  wire                     penable,
	input  wire                     pwrite,
	input  wire [ptr_pkg::APB_AW-1:0] paddr,
	input  wire [ptr_pkg::APB_DW-1:0] pwdata,
	output logic [ptr_pkg::APB_DW-1:0] prdata,
	output logic                    pready
);
	import ptr_pkg::*;

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	logic       direction_q;
	logic       v1_q;
	logic       v2_q;
	logic       v3_q;
	logic       en1;
	logic       en2;
	logic       en_out;
	data_t      comp_a_s1;
	data_t      comp_b_s1;
	logic [1:0] quad_s1;
	logic       dir_s1;
	trig_t      trig;
	data_t      sv;
	data_t      cv;
	data_t      sin_q;
	data_t      cos_q;
	cell_ctl_t  ctl_first;
	cell_ctl_t  ctl_second;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DIRECTION) ? {{(APB_DW-1){1'b0}}, direction_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_FORWARD;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION)) begin
			direction_q <= pwdata[0];
		end
	end

	assign en_out    = !v3_q || res.ready;
	assign en2       = !v2_q || en_out;
	assign en1       = !v1_q || en2;
	assign vec.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= vec.valid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en_out) begin
				v3_q <= v2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			comp_a_s1 <= vec.first_component;
			comp_b_s1 <= vec.second_component;
			quad_s1   <= vec.rotor_angle[ANGLE_WIDTH-1 -: 2];
			dir_s1    <= direction_q;
		end
	end

	ptr_rom u_rom (
		.clk     (clk),
		.rd_en   (en1),
		.addr    (vec.rotor_angle[OFF_WIDTH-1:0]),
		.rd_data (trig)
	);

	assign sv = data_t'({1'b0, trig.sin_v});
	assign cv = data_t'({1'b0, trig.cos_v});

	always_comb begin
		case (quad_s1)
			QUAD_I: begin
				sin_q = sv;
				cos_q = cv;
			end
			QUAD_II: begin
				sin_q = cv;
				cos_q = -sv;
			end
			QUAD_III: begin
				sin_q = -sv;
				cos_q = -cv;
			end
			QUAD_IV: begin
				sin_q = -cv;
				cos_q = sv;
			end
			default: begin
				sin_q = sv;
				cos_q = cv;
			end
		endcase
	end

	assign ctl_first  = '{en_a: en2, en_b: en_out, sub: (dir_s1 == DIR_INVERSE)};
	assign ctl_second = '{en_a: en2, en_b: en_out, sub: (dir_s1 == DIR_FORWARD)};

	ptr_cell u_cell_first (
		.clk   (clk),
		.ctl   (ctl_first),
		.a     (comp_a_s1),
		.b     (comp_b_s1),
		.sin_v (sin_q),
		.cos_v (cos_q),
		.res   (res.first_result)
	);

	ptr_cell u_cell_second (
		.clk   (clk),
		.ctl   (ctl_second),
		.a     (comp_b_s1),
		.b     (comp_a_s1),
		.sin_v (sin_q),
		.cos_v (cos_q),
		.res   (res.second_result)
	);

	assign res.valid = v3_q;
endmodule

`default_nettype wire

// ===== hw/rtl/ptr_checker.sv =====
`default_nettype none

module ptr_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_ready,
	input wire                 out_valid,
	input wire                 out_ready,
	input ptr_pkg::res_t       out_first,
	input ptr_pkg::res_t       out_second
);
	import ptr_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_first) && $stable(out_second))
		else $error("result payload changed while stalled");

	// The input side only stalls when every stage is full behind a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with room in the pipeline");

	assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

	// An empty, unstalled pipeline carries a request through table, product, output regs.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid && out_ready ##1 out_ready ##1 out_ready
		|=> out_valid)
		else $error("result missing three cycles after request");
endmodule

bind park_transform_core ptr_checker u_ptr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (vec.valid),
	.in_ready   (vec.ready),
	.out_valid  (res.valid),
	.out_ready  (res.ready),
	.out_first  (res.first_result),
	.out_second (res.second_result)
);

`default_nettype wire
